/* hw/rtl/lsq_pkg.sv */
package lsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ROB_WINDOW  = 4;
    localparam int HEAD_FIELDS = 4;

    localparam int ID_W    = 32;
    localparam int ADDR_W  = 32;
    localparam int WCNT_W  = 3;
    localparam int LIM_W   = 5;
    localparam int OUT_W   = 5;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam int S_DATA_W = 200;
    localparam int M_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_RETIRE   = 2'd2,
        REQ_QUERY    = 2'd3
    } req_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_LIMIT = 1'b0,
        CFG_ROB_GATED   = 1'b1
    } cfg_reg_e;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_CAPTURE,
        CMD_EVAL,
        CMD_COMPACT
    } cell_cmd_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COMPACT
    } lsq_state_e;

    typedef struct packed {
        logic [ID_W-1:0]   msg_id;
        logic [ADDR_W-1:0] addr;
        logic              is_store;
        logic              ready;
    } entry_t;

    typedef logic [HEAD_FIELDS-1:0][ID_W-1:0] head_ids_t;

    typedef struct packed {
        cell_cmd_e              cmd;
        req_e                   req;
        logic                   alloc_ok;
        logic                   gated;
        logic [HEAD_FIELDS-1:0] win_en;
    } cell_ctrl_t;

endpackage

/* hw/rtl/load_store_queue.sv */
// Ordered load-store queue built as a row of entry cells, oldest in cell 0.
// s_tuser carries the request kind (allocate, complete, retire tick, store
// query); every request yields one result transaction on m_. A request is
// handled in a capture step and a resolve step: the accept edge latches every
// cell's id, address and retire compares, and the resolve step then resolves
// the oldest match through the cell chain, updates the cells and loads the
// result register. A retire tick that removes entries is followed by
// compaction, where gaps move up one cell per cycle; the next request is taken
// only once compaction ends. The block waits in the resolve cycle while a
// previous result is not yet taken. Configuration writes are accepted at any time.
module load_store_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // msg_id, mem_addr, is_store, rob_window_count, rob_head_id0..3, zero pad
    input  logic [lsq_pkg::S_DATA_W-1:0]         s_tdata,
    // req_type
    input  logic [1:0]                           s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accepted, retired_count, store_hit, occupancy, zero pad
    output logic [lsq_pkg::M_DATA_W-1:0]         m_tdata,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsq_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int N = lsq_pkg::QUEUE_DEPTH;

    // input field unpacking
    logic [lsq_pkg::ID_W-1:0]   in_msg_id;
    logic [lsq_pkg::ADDR_W-1:0] in_addr;
    logic                       in_is_store;
    logic [lsq_pkg::WCNT_W-1:0] in_wcnt;
    lsq_pkg::head_ids_t         in_heads;

    assign in_msg_id   = s_tdata[31:0];
    assign in_addr     = s_tdata[63:32];
    assign in_is_store = s_tdata[64];
    assign in_wcnt     = s_tdata[67:65];
    assign in_heads[0] = s_tdata[99:68];
    assign in_heads[1] = s_tdata[131:100];
    assign in_heads[2] = s_tdata[163:132];
    assign in_heads[3] = s_tdata[195:164];

    // configuration
    logic [lsq_pkg::LIM_W-1:0] limit_reg;
    logic                      gated_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= lsq_pkg::LIM_W'(16);
            gated_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lsq_pkg::cfg_reg_e'(cfg_index))
                lsq_pkg::CFG_ENTRY_LIMIT: limit_reg <= cfg_wdata[lsq_pkg::LIM_W-1:0];
                lsq_pkg::CFG_ROB_GATED:   gated_reg <= cfg_wdata[0];
            endcase
        end
    end

    // request held for the resolve cycle
    lsq_pkg::req_e   req_reg;
    lsq_pkg::entry_t alloc_reg;

    // control
    lsq_pkg::lsq_state_e state_reg, state_next;
    logic [lsq_pkg::CNT_W-1:0] held_reg, held_next;
    logic                      out_valid_reg, out_valid_next;
    logic [lsq_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    lsq_pkg::cell_ctrl_t       ctrl;
    logic                      s_accept;
    logic                      out_free;
    logic                      alloc_ok;
    logic [lsq_pkg::HEAD_FIELDS-1:0] win_en;

    // cell row
    lsq_pkg::entry_t cell_entry [N];
    logic [N-1:0]    cell_valid;
    logic [N-1:0]    cell_found;
    logic [N-1:0]    cell_drop;
    logic [N-1:0]    cell_hit;
    logic [lsq_pkg::CNT_W-1:0] gone;
    logic            bubble;
    logic            accepted;
    logic [lsq_pkg::OUT_W-1:0] retired;

    assign s_tready = (state_reg == lsq_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        for (int k = 0; k < lsq_pkg::HEAD_FIELDS; k++) begin
            win_en[k] = (k < lsq_pkg::ROB_WINDOW) && (lsq_pkg::WCNT_W'(k) < in_wcnt);
        end
    end

    assign alloc_ok = (lsq_pkg::CMP_W'(held_reg) < lsq_pkg::CMP_W'(limit_reg))
                      && (held_reg < lsq_pkg::CNT_W'(N));

    always_comb begin
        gone = '0;
        for (int i = 0; i < N; i++) begin
            gone = gone + lsq_pkg::CNT_W'(cell_drop[i]);
        end
    end

    always_comb begin
        bubble = 1'b0;
        for (int i = 0; i < N - 1; i++) begin
            if (!cell_valid[i] && cell_valid[i+1]) begin
                bubble = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg            <= lsq_pkg::req_e'(s_tuser);
            alloc_reg.msg_id   <= in_msg_id;
            alloc_reg.addr     <= in_addr;
            alloc_reg.is_store <= in_is_store;
            alloc_reg.ready    <= 1'b0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        accepted       = 1'b0;
        retired        = '0;
        ctrl.cmd       = lsq_pkg::CMD_HOLD;
        ctrl.req       = req_reg;
        ctrl.alloc_ok  = alloc_ok;
        ctrl.gated     = gated_reg;
        ctrl.win_en    = win_en;
        unique case (state_reg)
            lsq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    ctrl.cmd   = lsq_pkg::CMD_CAPTURE;
                    state_next = lsq_pkg::ST_EVAL;
                end
            end
            lsq_pkg::ST_EVAL: begin
                if (out_free) begin
                    ctrl.cmd = lsq_pkg::CMD_EVAL;
                    unique case (req_reg)
                        lsq_pkg::REQ_ALLOC: begin
                            accepted = alloc_ok;
                            if (alloc_ok) begin
                                held_next = held_reg + lsq_pkg::CNT_W'(1);
                            end
                        end
                        lsq_pkg::REQ_COMPLETE: accepted = cell_found[N-1];
                        lsq_pkg::REQ_RETIRE: begin
                            held_next = held_reg - gone;
                            retired   = lsq_pkg::OUT_W'(gone);
                        end
                        lsq_pkg::REQ_QUERY: begin
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0000, lsq_pkg::OUT_W'(held_next),
                                      (req_reg == lsq_pkg::REQ_QUERY) && (|cell_hit),
                                      retired, accepted};
                    if ((req_reg == lsq_pkg::REQ_RETIRE) && (gone != '0)) begin
                        state_next = lsq_pkg::ST_COMPACT;
                    end else begin
                        state_next = lsq_pkg::ST_IDLE;
                    end
                end
            end
            lsq_pkg::ST_COMPACT: begin
                if (bubble) begin
                    ctrl.cmd = lsq_pkg::CMD_COMPACT;
                end else begin
                    state_next = lsq_pkg::ST_IDLE;
                end
            end
            default: state_next = lsq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lsq_pkg::ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        lsq_pkg::entry_t up_entry;
        logic            up_valid;
        logic            low_valid;
        logic            found_prev;

        if (i == N - 1) begin : g_top
            assign up_entry = '0;
            assign up_valid = 1'b0;
        end else begin : g_mid
            assign up_entry = cell_entry[i+1];
            assign up_valid = cell_valid[i+1];
        end

        if (i == 0) begin : g_head
            assign low_valid  = 1'b1;
            assign found_prev = 1'b0;
        end else begin : g_rest
            assign low_valid  = cell_valid[i-1];
            assign found_prev = cell_found[i-1];
        end

        lsq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .cmp_id      (in_msg_id),
            .cmp_addr    (in_addr),
            .heads       (in_heads),
            .new_entry   (alloc_reg),
            .upper_entry (up_entry),
            .upper_valid (up_valid),
            .lower_valid (low_valid),
            .found_in    (found_prev),
            .entry_out   (cell_entry[i]),
            .valid_out   (cell_valid[i]),
            .found_out   (cell_found[i]),
            .drop_out    (cell_drop[i]),
            .hit_out     (cell_hit[i])
        );
    end

endmodule

/* hw/rtl/lsq_cell.sv */
module lsq_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lsq_pkg::cell_ctrl_t         ctrl,
    input  logic [lsq_pkg::ID_W-1:0]    cmp_id,
    input  logic [lsq_pkg::ADDR_W-1:0]  cmp_addr,
    input  lsq_pkg::head_ids_t          heads,
    input  lsq_pkg::entry_t             new_entry,
    input  lsq_pkg::entry_t             upper_entry,
    input  logic                        upper_valid,
    input  logic                        lower_valid,
    input  logic                        found_in,
    output lsq_pkg::entry_t             entry_out,
    output logic                        valid_out,
    output logic                        found_out,
    output logic                        drop_out,
    output logic                        hit_out
);

    lsq_pkg::entry_t entry_reg, entry_next;
    logic valid_reg, valid_next;
    logic idm_reg, idm_next;
    logic hit_reg, hit_next;
    logic drop_reg, drop_next;
    logic in_win;

    always_comb begin
        in_win = 1'b0;
        for (int k = 0; k < lsq_pkg::HEAD_FIELDS; k++) begin
            if (ctrl.win_en[k] && (heads[k] == entry_reg.msg_id)) begin
                in_win = 1'b1;
            end
        end
    end

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        idm_next   = idm_reg;
        hit_next   = hit_reg;
        drop_next  = drop_reg;
        unique case (ctrl.cmd)
            lsq_pkg::CMD_HOLD: begin
            end
            lsq_pkg::CMD_CAPTURE: begin
                idm_next  = valid_reg && !entry_reg.ready && (entry_reg.msg_id == cmp_id);
                hit_next  = valid_reg && entry_reg.is_store && (entry_reg.addr == cmp_addr);
                drop_next = valid_reg && entry_reg.ready
                            && (!entry_reg.is_store || !ctrl.gated || in_win);
            end
            lsq_pkg::CMD_EVAL: begin
                unique case (ctrl.req)
                    lsq_pkg::REQ_ALLOC: begin
                        if (ctrl.alloc_ok && !valid_reg && lower_valid) begin
                            entry_next = new_entry;
                            valid_next = 1'b1;
                        end
                    end
                    lsq_pkg::REQ_COMPLETE: begin
                        if (idm_reg && !found_in) begin
                            entry_next.ready = 1'b1;
                        end
                    end
                    lsq_pkg::REQ_RETIRE: begin
                        if (drop_reg) begin
                            valid_next = 1'b0;
                        end
                    end
                    lsq_pkg::REQ_QUERY: begin
                    end
                endcase
            end
            lsq_pkg::CMD_COMPACT: begin
                // holes bubble upward, entries slide down one cell per cycle
                if (!valid_reg) begin
                    entry_next = upper_entry;
                    valid_next = upper_valid;
                end else if (!lower_valid) begin
                    valid_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idm_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            idm_reg   <= idm_next;
            hit_reg   <= hit_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign valid_out = valid_reg;
    assign found_out = found_in | idm_reg;
    assign drop_out  = drop_reg;
    assign hit_out   = hit_reg;

endmodule

/* bench/load_store_queue_tb.sv */
module load_store_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = lsq_pkg::QUEUE_DEPTH + 4;
    localparam int PHASES         = 10;
    localparam int PHASE_REQUESTS = 200;
    localparam int DIRECTED_ROWS  = 28;

    localparam lsq_pkg::head_ids_t NO_HEADS  = '0;
    localparam lsq_pkg::head_ids_t ALL_HEADS = '1;

    typedef struct packed {
        logic       accepted;
        logic [4:0] retired;
        logic       hit;
        logic [4:0] occupancy;
    } lsq_result_t;

    typedef struct packed {
        bit                 is_cfg;
        lsq_pkg::cfg_reg_e  cfg_idx;
        logic [4:0]         cfg_val;
        lsq_pkg::req_e      req;
        logic [31:0]        id;
        logic [31:0]        addr;
        logic               st;
        logic [2:0]         wcnt;
        lsq_pkg::head_ids_t heads;
        bit                 typed;
        lsq_result_t        want;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lsq_pkg::S_DATA_W-1:0]   s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lsq_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lsq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lsq_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // queue mirror
    logic [31:0] q_id    [lsq_pkg::QUEUE_DEPTH];
    logic [31:0] q_addr  [lsq_pkg::QUEUE_DEPTH];
    bit          q_store [lsq_pkg::QUEUE_DEPTH];
    bit          q_ready [lsq_pkg::QUEUE_DEPTH];
    int unsigned held = 0;
    logic [4:0]  lim_reg = 5'd16;
    bit          gated_reg = 1'b1;

    lsq_result_t pending_results[$];
    stim_row_t   directed_rows[DIRECTED_ROWS];

    int          errors = 0;
    int          s_gap_pct = 20;
    int          m_stall_pct = 20;
    int          idle_cycles = 0;
    int          n_kind[4] = '{0, 0, 0, 0};
    int          n_cfg = 0;
    int          n_hits = 0;
    int          n_retired = 0;
    int          peak_held = 0;

    load_store_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic stim_row_t mk_req(input lsq_pkg::req_e req, input logic [31:0] id,
                                         input logic [31:0] addr, input logic st,
                                         input logic [2:0] wcnt,
                                         input lsq_pkg::head_ids_t heads);
        stim_row_t r;
        r       = '0;
        r.req   = req;
        r.id    = id;
        r.addr  = addr;
        r.st    = st;
        r.wcnt  = wcnt;
        r.heads = heads;
        return r;
    endfunction

    function automatic stim_row_t with_result(input stim_row_t r, input int acc,
                                              input int ret, input int hit,
                                              input int occ);
        stim_row_t t;
        t                = r;
        t.typed          = 1'b1;
        t.want.accepted  = acc[0];
        t.want.retired   = 5'(ret);
        t.want.hit       = hit[0];
        t.want.occupancy = 5'(occ);
        return t;
    endfunction

    function automatic stim_row_t mk_cfg(input lsq_pkg::cfg_reg_e idx, input logic [4:0] val);
        stim_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    // updates the mirror and returns the expected result transaction
    function automatic lsq_result_t apply_request(input stim_row_t r);
        lsq_result_t res;
        int unsigned lim;
        int unsigned win;
        int unsigned keep;
        bit          drop;
        res = '0;
        case (r.req)
            lsq_pkg::REQ_ALLOC: begin
                lim = (lim_reg > lsq_pkg::QUEUE_DEPTH) ? lsq_pkg::QUEUE_DEPTH : 32'(lim_reg);
                if (held < lim) begin
                    q_id[held]    = r.id;
                    q_addr[held]  = r.addr;
                    q_store[held] = r.st;
                    q_ready[held] = 1'b0;
                    held++;
                    res.accepted = 1'b1;
                end
            end
            lsq_pkg::REQ_COMPLETE: begin
                for (int i = 0; i < held; i++) begin
                    if (q_id[i] == r.id && !q_ready[i]) begin
                        q_ready[i] = 1'b1;
                        res.accepted = 1'b1;
                        break;
                    end
                end
            end
            lsq_pkg::REQ_RETIRE: begin
                win = 32'(r.wcnt);
                if (win > lsq_pkg::ROB_WINDOW) win = lsq_pkg::ROB_WINDOW;
                if (win > lsq_pkg::HEAD_FIELDS) win = lsq_pkg::HEAD_FIELDS;
                keep = 0;
                for (int i = 0; i < held; i++) begin
                    drop = 1'b0;
                    if (q_ready[i]) begin
                        if (!q_store[i] || !gated_reg) begin
                            drop = 1'b1;
                        end else begin
                            for (int k = 0; k < win; k++)
                                if (r.heads[k] == q_id[i]) drop = 1'b1;
                        end
                    end
                    if (drop) begin
                        res.retired = res.retired + 5'd1;
                    end else begin
                        q_id[keep]    = q_id[i];
                        q_addr[keep]  = q_addr[i];
                        q_store[keep] = q_store[i];
                        q_ready[keep] = q_ready[i];
                        keep++;
                    end
                end
                held = keep;
            end
            default: begin
                for (int i = 0; i < held; i++) begin
                    if (q_addr[i] == r.addr && q_store[i]) begin
                        res.hit = 1'b1;
                        break;
                    end
                end
            end
        endcase
        res.occupancy = 5'(held);
        return res;
    endfunction

    // mostly ids and addresses from small pools or from live entries, so that
    // completes, window matches and store hits happen often
    function automatic stim_row_t random_request();
        stim_row_t   r;
        int unsigned roll;
        r      = '0;
        r.id   = $urandom;
        r.addr = $urandom;
        r.st   = 1'($urandom_range(0, 1));
        r.wcnt = 3'($urandom_range(0, 7));
        for (int k = 0; k < lsq_pkg::HEAD_FIELDS; k++) r.heads[k] = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 35) r.req = lsq_pkg::REQ_ALLOC;
        else if (roll < 60) r.req = lsq_pkg::REQ_COMPLETE;
        else if (roll < 80) r.req = lsq_pkg::REQ_RETIRE;
        else r.req = lsq_pkg::REQ_QUERY;
        case (r.req)
            lsq_pkg::REQ_ALLOC: begin
                if ($urandom_range(0, 9) != 0) r.id = $urandom_range(0, 11);
                if ($urandom_range(0, 9) != 0) r.addr = 32'h1000 + 4 * $urandom_range(0, 7);
            end
            lsq_pkg::REQ_COMPLETE: begin
                if (held != 0 && $urandom_range(0, 9) < 7)
                    r.id = q_id[$urandom_range(0, held - 1)];
                else if ($urandom_range(0, 1) != 0)
                    r.id = $urandom_range(0, 11);
            end
            lsq_pkg::REQ_RETIRE: begin
                for (int k = 0; k < lsq_pkg::HEAD_FIELDS; k++)
                    if (held != 0 && $urandom_range(0, 9) < 6)
                        r.heads[k] = q_id[$urandom_range(0, held - 1)];
            end
            default: begin
                if (held != 0 && $urandom_range(0, 9) < 6)
                    r.addr = q_addr[$urandom_range(0, held - 1)];
                else if ($urandom_range(0, 1) != 0)
                    r.addr = 32'h1000 + 4 * $urandom_range(0, 7);
            end
        endcase
        return r;
    endfunction

    task automatic drive_request(input stim_row_t r);
        lsq_result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= r.req;
        s_tdata  <= {4'b0, r.heads, r.wcnt, r.st, r.addr, r.id};
        do @(posedge aclk); while (!s_tready);
        res = apply_request(r);
        pending_results.insert(pending_results.size(), r.typed ? r.want : res);
        n_kind[r.req]++;
        n_hits    += int'(res.hit);
        n_retired += int'(res.retired);
        if (held > peak_held) peak_held = held;
    endtask

    task automatic idle_sender();
        if (s_gap_pct != 0 && $urandom_range(0, 99) < s_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // compaction may still be running after the last result
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input lsq_pkg::cfg_reg_e idx, input logic [4:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == lsq_pkg::CFG_ENTRY_LIMIT) lim_reg = val;
        else gated_reg = val[0];
        n_cfg++;
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (m_stall_pct != 0 && $urandom_range(0, 99) < m_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        lsq_result_t got;
        lsq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted  = m_tdata[0];
            got.retired   = m_tdata[5:1];
            got.hit       = m_tdata[6];
            got.occupancy = m_tdata[11:7];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %0d actual %0d",
                             $time, want.accepted, got.accepted);
                    errors++;
                end
                if (got.retired !== want.retired) begin
                    $display("%0t: retired_count expected %0d actual %0d",
                             $time, want.retired, got.retired);
                    errors++;
                end
                if (got.hit !== want.hit) begin
                    $display("%0t: store_hit expected %0d actual %0d",
                             $time, want.hit, got.hit);
                    errors++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, got.occupancy);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("load_store_queue regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [4:0] lim;
        bit         g;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= lsq_pkg::REQ_ALLOC;
        cfg_valid <= 1'b0;
        cfg_index <= lsq_pkg::CFG_ENTRY_LIMIT;
        cfg_wdata <= '0;

        directed_rows = '{
            with_result(mk_req(lsq_pkg::REQ_QUERY, 32'd0, 32'd0, 1'b1, 3'd0, NO_HEADS),
                        0, 0, 0, 0),
            with_result(mk_req(lsq_pkg::REQ_RETIRE, 32'd0, 32'd0, 1'b0, 3'd7, ALL_HEADS),
                        0, 0, 0, 0),
            with_result(mk_req(lsq_pkg::REQ_COMPLETE, '1, '1, 1'b1, 3'd7, ALL_HEADS),
                        0, 0, 0, 0),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, '1, '1, 1'b1, 3'd0, NO_HEADS),
                        1, 0, 0, 1),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, 32'd0, 32'd0, 1'b0, 3'd7, ALL_HEADS),
                        1, 0, 0, 2),
            with_result(mk_req(lsq_pkg::REQ_QUERY, 32'd0, '1, 1'b0, 3'd0, NO_HEADS),
                        0, 0, 1, 2),
            with_result(mk_req(lsq_pkg::REQ_QUERY, '1, 32'd0, 1'b1, 3'd0, NO_HEADS),
                        0, 0, 0, 2),
            with_result(mk_req(lsq_pkg::REQ_COMPLETE, 32'd0, '1, 1'b0, 3'd0, NO_HEADS),
                        1, 0, 0, 2),
            with_result(mk_req(lsq_pkg::REQ_COMPLETE, '1, 32'd0, 1'b0, 3'd0, NO_HEADS),
                        1, 0, 0, 2),
            // already ready: no match left
            with_result(mk_req(lsq_pkg::REQ_COMPLETE, '1, 32'd0, 1'b0, 3'd0, NO_HEADS),
                        0, 0, 0, 2),
            // empty window: the ready store stays, the ready load goes
            with_result(mk_req(lsq_pkg::REQ_RETIRE, 32'd0, 32'd0, 1'b0, 3'd0, ALL_HEADS),
                        0, 1, 0, 1),
            // count 7 saturates to 4, so head 3 still matches
            with_result(mk_req(lsq_pkg::REQ_RETIRE, 32'd0, 32'd0, 1'b0, 3'd7,
                               {32'hFFFF_FFFF, 32'd3, 32'd2, 32'd1}), 0, 1, 0, 0),
            mk_req(lsq_pkg::REQ_ALLOC, 32'd5, 32'h10, 1'b1, 3'd0, NO_HEADS),
            mk_req(lsq_pkg::REQ_ALLOC, 32'd5, 32'h20, 1'b1, 3'd0, NO_HEADS),
            mk_req(lsq_pkg::REQ_ALLOC, 32'd6, 32'h30, 1'b0, 3'd0, NO_HEADS),
            mk_req(lsq_pkg::REQ_COMPLETE, 32'd5, 32'd0, 1'b0, 3'd0, NO_HEADS),
            mk_req(lsq_pkg::REQ_COMPLETE, 32'd6, 32'd0, 1'b0, 3'd0, NO_HEADS),
            mk_req(lsq_pkg::REQ_RETIRE, 32'd0, 32'd0, 1'b0, 3'd1,
                   {32'd0, 32'd0, 32'd5, 32'd7}),
            mk_cfg(lsq_pkg::CFG_ROB_GATED, 5'd0),
            mk_req(lsq_pkg::REQ_RETIRE, 32'd0, 32'd0, 1'b0, 3'd0, NO_HEADS),
            mk_cfg(lsq_pkg::CFG_ENTRY_LIMIT, 5'd0),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, 32'd9, 32'h40, 1'b0, 3'd0, NO_HEADS),
                        0, 0, 0, 1),
            mk_cfg(lsq_pkg::CFG_ENTRY_LIMIT, 5'd2),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, 32'd10, 32'h40, 1'b0, 3'd0, NO_HEADS),
                        1, 0, 0, 2),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, 32'd11, 32'h44, 1'b1, 3'd0, NO_HEADS),
                        0, 0, 0, 2),
            mk_cfg(lsq_pkg::CFG_ENTRY_LIMIT, 5'd31),
            with_result(mk_req(lsq_pkg::REQ_ALLOC, 32'd12, 32'h48, 1'b1, 3'd0, NO_HEADS),
                        1, 0, 0, 3),
            mk_cfg(lsq_pkg::CFG_ROB_GATED, 5'd1)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end else begin
                drive_request(directed_rows[i]);
                idle_sender();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lim = 5'd31; g = 1'b1; end
                1: begin lim = 5'd1;  g = 1'b0; end
                2: begin lim = 5'd16; g = 1'b1; end
                3: begin lim = 5'd0;  g = 1'b0; end
                4: begin lim = 5'd17; g = 1'b1; end
                default: begin
                    lim = 5'($urandom_range(0, 31));
                    g   = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(lsq_pkg::CFG_ENTRY_LIMIT, lim);
            write_reg(lsq_pkg::CFG_ROB_GATED, {4'b0, g});
            if (p == PHASES - 1) begin
                s_gap_pct   = 0;
                m_stall_pct = 0;
            end else begin
                s_gap_pct   = 10 * $urandom_range(0, 3);
                m_stall_pct = 10 * $urandom_range(0, 3);
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                drive_request(random_request());
                idle_sender();
            end
        end

        drain_results();

        $display("covered %0d requests: %0d allocate, %0d complete, %0d retire, %0d query;",
                 n_kind[0] + n_kind[1] + n_kind[2] + n_kind[3],
                 n_kind[lsq_pkg::REQ_ALLOC], n_kind[lsq_pkg::REQ_COMPLETE],
                 n_kind[lsq_pkg::REQ_RETIRE], n_kind[lsq_pkg::REQ_QUERY]);
        $display("%0d register writes, store hits %0d, entries retired %0d, peak occupancy %0d",
                 n_cfg, n_hits, n_retired, peak_held);
        if (errors == 0) begin
            $display("load_store_queue regression: pass");
        end else begin
            $display("load_store_queue regression: fail");
        end
        $finish;
    end

endmodule
